@@ design/sobel_sharpen_3x3_assert.svh @@
// Assertion macros for the sobel_sharpen_3x3 block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SOBEL_SHARPEN_3X3_ASSERT_SVH
`define SOBEL_SHARPEN_3X3_ASSERT_SVH
`ifndef SYNTHESIS
// expr must hold at every rising clock edge outside reset
`define SOBSH_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// when ante holds, cons must hold in the next cycle
`define SOBSH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOBSH_ASSERT(name, expr, msg)
`define SOBSH_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ design/sobsh_pkg.sv @@
package sobsh_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam int SIZE_RST = 512;

  // clamp limits
  localparam int MIN_SIZE = 3;
  localparam int PIX_MAX  = 255;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_DIRECTION = 2'd2
  } cfg_idx_e;

  // per-item control carried from position tracking to the result stage
  typedef struct packed {
    logic has_res;  // item produces a result
    logic border;   // result pixel is on the frame border: copy the center
    logic eof;      // result is the last of the frame
  } item_tag_t;

endpackage

@@ design/sobsh_ctrl.sv @@
module sobsh_ctrl import sobsh_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic                          accept_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output item_tag_t                     tag_o,
  output logic                          dir_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam int RST_W    = (SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : SIZE_RST;
  localparam int RST_H    = (SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RST;
  localparam int RST_AREA = RST_W * RST_H;

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             dir_q, dir_d;
  logic             restart;

  logic [WW-1:0] weff_q, weff_d;
  logic [HW-1:0] heff_q, heff_d;
  logic [AW-1:0] area_q, area_d;

  logic [CW-1:0] col_q, col_d, col;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          last_col;
  item_tag_t     tag;

  // register writes; a size write restarts the frame
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    dir_d    = dir_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH: begin
          width_d = cfg_data_i;
          restart = 1'b1;
        end
        CFG_HEIGHT: begin
          height_d = cfg_data_i;
          restart  = 1'b1;
        end
        CFG_DIRECTION: begin
          dir_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective frame size, clamped to 3..MAX, and its pixel count
  always_comb begin
    if (32'(width_d) < MIN_SIZE) begin
      weff_d = WW'(MIN_SIZE);
    end else if (32'(width_d) > MAX_WIDTH) begin
      weff_d = WW'(MAX_WIDTH);
    end else begin
      weff_d = WW'(width_d);
    end
    if (32'(height_d) < MIN_SIZE) begin
      heff_d = HW'(MIN_SIZE);
    end else if (32'(height_d) > MAX_HEIGHT) begin
      heff_d = HW'(MAX_HEIGHT);
    end else begin
      heff_d = HW'(height_d);
    end
    area_d = AW'(32'(weff_d) * 32'(heff_d));
  end

  // position of the current item and what its result is
  always_comb begin
    col      = (32'(col_q) >= 32'(weff_q)) ? '0 : col_q;
    last_col = (32'(col) + 1 >= 32'(weff_q));
    tag.has_res = (32'(row_q) >= 2) || ((32'(row_q) == 1) && (col != '0));
    // the window center is on a border column or row
    tag.border  = (col == '0) || (32'(col) == 1) || (32'(row_q) == 1) ||
                  (32'(row_q) >= 32'(heff_q));
    tag.eof     = tag.has_res && (32'(cnt_q) + 1 >= 32'(area_q));
  end

  // counter clear on restart, advance per transfer
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
      cnt_d = '0;
    end else if (accept_i) begin
      if (tag.eof) begin
        col_d = '0;
        row_d = '0;
        cnt_d = '0;
      end else begin
        col_d = last_col ? '0 : CW'(32'(col) + 1);
        row_d = last_col ? RW'(32'(row_q) + 1) : row_q;
        cnt_d = tag.has_res ? AW'(32'(cnt_q) + 1) : cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(SIZE_RST);
      height_q <= CFG_W'(SIZE_RST);
      dir_q    <= 1'b0;
      weff_q   <= WW'(RST_W);
      heff_q   <= HW'(RST_H);
      area_q   <= AW'(RST_AREA);
      col_q    <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      dir_q    <= dir_d;
      weff_q   <= weff_d;
      heff_q   <= heff_d;
      area_q   <= area_d;
      col_q    <= col_d;
      row_q    <= row_d;
      cnt_q    <= cnt_d;
    end
  end

  assign col_o = col;
  assign tag_o = tag;
  assign dir_o = dir_q;

endmodule

@@ design/sobsh_line_buf.sv @@
module sobsh_line_buf import sobsh_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  pix_t                         wr_pix_i,
  output pix_t                         top_o,
  output pix_t                         mid_o
);

  // two rows above the newest one
  pix_t top_mem [MAX_WIDTH];
  pix_t mid_mem [MAX_WIDTH];
  pix_t top_q;
  pix_t mid_q;

  // registered read at the column of an incoming transfer
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      top_q <= top_mem[rd_addr_i];
      mid_q <= mid_mem[rd_addr_i];
    end
  end

  // rows move up one line: mid goes to top, new pixel goes to mid
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      top_mem[wr_addr_i] <= mid_q;
      mid_mem[wr_addr_i] <= wr_pix_i;
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule

@@ design/sobsh_kernel.sv @@
module sobsh_kernel import sobsh_pkg::*; (
  input  logic clk_i,
  input  logic shift_i,
  input  logic dir_i,
  input  logic border_i,
  input  pix_t top_i,
  input  pix_t mid_i,
  input  pix_t bot_i,
  output pix_t res_o
);

  // 3x3 window, row-major: 0..2 top, 3..5 middle, 6..8 bottom
  pix_t win_q [9];
  pix_t win_d [9];

  logic        [PIX_W+1:0] sum_a, sum_b;
  logic signed [PIX_W+3:0] total;

  // shift left and load the new right column
  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = top_i;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = mid_i;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = bot_i;
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= win_d;
    end
  end

  // gradient with 1,2,1 weights, then center plus gradient clamped; on the border the center passes
  always_comb begin
    if (!dir_i) begin
      sum_a = {2'b0, win_d[6]} + {1'b0, win_d[7], 1'b0} + {2'b0, win_d[8]};
      sum_b = {2'b0, win_d[0]} + {1'b0, win_d[1], 1'b0} + {2'b0, win_d[2]};
    end else begin
      sum_a = {2'b0, win_d[2]} + {1'b0, win_d[5], 1'b0} + {2'b0, win_d[8]};
      sum_b = {2'b0, win_d[0]} + {1'b0, win_d[3], 1'b0} + {2'b0, win_d[6]};
    end
    total = $signed({4'b0, win_d[4]}) + $signed({2'b0, sum_a}) - $signed({2'b0, sum_b});
    if (border_i) begin
      res_o = win_d[4];
    end else if (total < 0) begin
      res_o = '0;
    end else if (total > PIX_MAX) begin
      res_o = PIX_W'(PIX_MAX);
    end else begin
      res_o = total[PIX_W-1:0];
    end
  end

endmodule

@@ design/sobel_sharpen_3x3.sv @@
// Streaming 3x3 Sobel edge sharpening of 8-bit gray pixels in raster order. One pixel
// is taken per clock: a transfer registers the pixel and reads the two line memories
// at its column, and as stage 1 moves on the window shifts and center plus gradient
// (rows for direction 0, columns for direction 1) lands in the output register. A
// result left waiting in the output register holds stage 1, and with it the input.
// The result for a pixel appears on the transfer that brings the pixel one line plus
// one position later, so after a frame push the effective width plus one flush items;
// the last result has end_of_frame set. Border pixels leave unchanged. Sizes are
// clamped to 3..MAX_WIDTH/MAX_HEIGHT; writing either size restarts the frame. The line
// memories are not cleared after reset: their startup contents reach no result.
`include "sobel_sharpen_3x3_assert.svh"

module sobel_sharpen_3x3 import sobsh_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 flush_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic                 end_of_frame_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          in_fire;
  logic          s1_adv;
  logic [CW-1:0] col;
  item_tag_t     tag;
  logic          dir;
  pix_t          top, mid, res;

  logic          s1_valid_q;
  item_tag_t     s1_tag_q;
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_col_q;

  logic          out_valid_q;
  pix_t          out_pix_q;
  logic          out_eof_q;

  // handshake: stage 1 moves on unless its result is blocked by a full output register not being read
  assign s1_adv     = s1_valid_q && (!s1_tag_q.has_res || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  sobsh_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (in_fire),
    .col_o     (col),
    .tag_o     (tag),
    .dir_o     (dir)
  );

  sobsh_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (in_fire),
    .rd_addr_i(col),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_col_q),
    .wr_pix_i (s1_pix_q),
    .top_o    (top),
    .mid_o    (mid)
  );

  sobsh_kernel u_kernel (
    .clk_i   (clk_i),
    .shift_i (s1_adv),
    .dir_i   (dir),
    .border_i(s1_tag_q.border),
    .top_i   (top),
    .mid_i   (mid),
    .bot_i   (s1_pix_q),
    .res_o   (res)
  );

  // stage 1 occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_tag_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        s1_tag_q   <= tag;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // stage 1 payload; a flush item counts as a zero pixel
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= flush_i ? '0 : pixel_in_i;
      s1_col_q <= col;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv && s1_tag_q.has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_tag_q.has_res) begin
      out_pix_q <= res;
      out_eof_q <= s1_tag_q.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign end_of_frame_o = out_eof_q;

  // checks
  `SOBSH_ASSERT(a_stall_only_when_busy, !in_ready_o |-> s1_valid_q,
                "input stalled with stage 1 empty")
  `SOBSH_ASSERT_NEXT(a_result_lands, s1_adv && s1_tag_q.has_res, out_valid_q,
                     "result lost after stage 1")
  `SOBSH_ASSERT(a_no_overwrite, s1_tag_q.has_res && out_valid_q && !out_ready_i |-> !s1_adv,
                "output register overwritten")
  `SOBSH_ASSERT_NEXT(a_eof_has_result, s1_adv && s1_tag_q.eof, out_valid_q && out_eof_q,
                     "end of frame without result")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import sobsh_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  // the block may still hold result-less items once the last result is out
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 110;
  localparam int NOISE_PCT = 6;
  localparam longint TIMEOUT_NS = 64'd10_000_000;
  // index with no register behind it: writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    pix_t pixel;
    logic eof;
  } sharp_result_t;

  // Tracks the sharpening stream: line buffers, window, frame position and the
  // results still owed by the block.
  class sharpen_board;
    pix_t lines[2*MAX_W];
    pix_t win[9];
    int in_col, in_row, out_count;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic dir_reg;
    sharp_result_t expected_pixels[$];
    int errors;

    function new();
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i]) win[i] = '0;
      width_reg = CFG_W'(SIZE_RST);
      height_reg = CFG_W'(SIZE_RST);
      dir_reg = 1'b0;
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_col = 0;
      in_row = 0;
      out_count = 0;
    endfunction

    function int clamp_size(int v, int maxv);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int eff_width();
      return clamp_size(int'(width_reg), MAX_W);
    endfunction

    function int eff_height();
      return clamp_size(int'(height_reg), MAX_H);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WIDTH: begin
          width_reg = data;
          restart_frame();
        end
        CFG_HEIGHT: begin
          height_reg = data;
          restart_frame();
        end
        CFG_DIRECTION: begin
          dir_reg = data[0];
        end
        default: ;
      endcase
    endfunction

    // one accepted pixel: update the window and queue its result, if any
    function void note_pixel(pix_t pix, logic flush);
      int w, h, col, row, orow, ocol, grad, res;
      pix_t v, top, mid;
      sharp_result_t r;
      w = eff_width();
      h = eff_height();
      col = in_col;
      row = in_row;
      v = flush ? '0 : pix;
      if (col >= w) col = 0;

      // two rows above the newest one, at this column
      top = lines[col];
      mid = lines[MAX_W + col];
      lines[col] = mid;
      lines[MAX_W + col] = v;

      win[0] = win[1]; win[1] = win[2]; win[2] = top;
      win[3] = win[4]; win[4] = win[5]; win[5] = mid;
      win[6] = win[7]; win[7] = win[8]; win[8] = v;

      in_col = col + 1;
      in_row = row;
      if (in_col >= w) begin
        in_col = 0;
        in_row = row + 1;
      end

      if (!(row >= 2 || (row == 1 && col >= 1))) return;

      // window center is the pixel one line plus one position back
      if (col >= 1) begin
        orow = row - 1;
        ocol = col - 1;
      end else begin
        orow = row - 2;
        ocol = w - 1;
      end

      if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
        res = int'(win[4]);
      end else begin
        if (!dir_reg)
          grad = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        else
          grad = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        res = int'(win[4]) + grad;
        if (res > PIX_MAX) res = PIX_MAX;
        if (res < 0) res = 0;
      end

      out_count++;
      r.pixel = pix_t'(res);
      r.eof = (out_count >= w * h);
      if (r.eof) restart_frame();
      expected_pixels.push_back(r);
    endfunction

    function void check_pixel(pix_t pix, logic eof);
      sharp_result_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("unexpected result: pixel_out %0d end_of_frame %0b", pix, eof);
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pixel) begin
        errors++;
        $error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
      end
      if (eof !== want.eof) begin
        errors++;
        $error("end_of_frame: expected %0b, actual %0b", want.eof, eof);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [PIX_W-1:0] pixel_in_i = '0;
  logic flush_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic [PIX_W-1:0] pixel_out_o;
  logic end_of_frame_o;

  sharpen_board board;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int items_sent = 0;

  sobel_sharpen_3x3 #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .pixel_in_i(pixel_in_i),
    .flush_i(flush_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o),
    .end_of_frame_o(end_of_frame_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_pixel(pixel_in_i, flush_i);
      if (out_valid_o && out_ready_i) board.check_pixel(pixel_out_o, end_of_frame_o);
    end
  end

  // result side: random stalls, or a long hold-off when one is asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // called and returning just after a falling edge; valid stays up after the transfer
  task automatic send_pixel(pix_t pix, logic flush);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    flush_i <= flush;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // pixels, then the flush items; a few of each kind swapped for noise
  task automatic send_frame(int n_pix, int n_flush, int noise_pct);
    int k;
    for (k = 0; k < n_pix; k++) begin
      if ($urandom_range(99) < noise_pct)
        send_pixel(8'($urandom), 1'b1);
      else if ($urandom_range(3) == 0)
        send_pixel($urandom_range(1) ? 8'hFF : 8'h00, 1'b0);
      else
        send_pixel(8'($urandom), 1'b0);
    end
    for (k = 0; k < n_flush; k++)
      send_pixel(8'($urandom), !($urandom_range(99) < noise_pct));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    pix_t top_heavy[9];
    pix_t right_heavy[9];
    int idle_plan[4];
    int stall_plan[4];
    int phase, k, start, n_pix, n_flush, w;
    bit partial;

    top_heavy = '{8'hFF, 8'hFF, 8'hFF, 8'd17, 8'h00, 8'd34, 8'h00, 8'h00, 8'h00};
    right_heavy = '{8'h00, 8'd9, 8'hFF, 8'hFF, 8'd200, 8'hFF, 8'h00, 8'd3, 8'hFF};
    idle_plan = '{0, 59, 0, 22};
    stall_plan = '{0, 0, 59, 22};
    board = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // smallest frame, vertical gradient from reset: center pulled down to 0
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd3);
    for (k = 0; k < 9; k++) send_pixel(top_heavy[k], 1'b0);
    for (k = 0; k < 4; k++) send_pixel(8'hFF, 1'b1);
    wait_drained();

    // horizontal gradient clamps at 255; flush inside the frame reads as 0,
    // real pixels in the flush tail
    write_reg(CFG_DIRECTION, 11'd1);
    write_reg(CFG_SPARE, 11'h7FF);
    for (k = 0; k < 9; k++) send_pixel(right_heavy[k], k == 3);
    for (k = 0; k < 4; k++) send_pixel(8'($urandom), 1'b0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if (phase == 0 && items_sent == start) begin
          // a frame long enough to back the block up behind a long hold-off
          write_reg(CFG_WIDTH, 11'd12);
          write_reg(CFG_HEIGHT, 11'd8);
          holds_asked++;
        end else begin
          // sizes 0..2 exercise the lower clamp
          if ($urandom_range(9) < 7) write_reg(CFG_WIDTH, 11'($urandom_range(12)));
          if ($urandom_range(9) < 7) write_reg(CFG_HEIGHT, 11'($urandom_range(8)));
        end
        if ($urandom_range(1)) write_reg(CFG_DIRECTION, 11'($urandom));
        w = board.eff_width();
        n_pix = w * board.eff_height();
        n_flush = w + 1;
        partial = ($urandom_range(9) == 0);
        if (partial) begin
          n_pix = $urandom_range(n_pix - 1, 1);
          n_flush = $urandom_range(w + 1);
        end
        send_frame(n_pix, n_flush, NOISE_PCT);
        wait_drained();
      end
    end

    if (board.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/sobsh_pkg.sv
design/sobsh_ctrl.sv
design/sobsh_line_buf.sv
design/sobsh_kernel.sv
design/sobel_sharpen_3x3.sv
sim/testbench.sv
